>>> sv/hcb_pkg.sv
// package for the huffman code builder: sizes, request and status codes, entry types
// no dependencies; imported by the top level
package hcb_pkg;

  localparam int SYMBOLS = 256;
  localparam int NODES   = 2 * SYMBOLS - 1;
  localparam int SYM_W   = 8;
  localparam int NODE_W  = 9;
  localparam int CNT_W   = 32;
  localparam int CODE_W  = 64;
  localparam int LEN_W   = 7;
  localparam int PLEN_W  = 8;

  // request kinds
  localparam logic [1:0] REQ_COUNT = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_UNBUILT  = 2'd3;

  // heap slot: node weight kept beside the node number
  typedef struct packed {
    logic [CNT_W-1:0]  w;
    logic [NODE_W-1:0] node;
  } heap_ent_t;

  // root-to-node path
  typedef struct packed {
    logic [PLEN_W-1:0] len;
    logic [CODE_W-1:0] bits;
  } path_ent_t;

endpackage

>>> sv/hcb_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module hcb_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/huffman_code_builder_core.sv
// huffman code builder top level: histogram, heap sequencer, code derivation, query
// depends on hcb_pkg and hcb_ram
// build sift steps are paced by the shared heap compare unit and heap ram port
// throughput: one request at a time; in_tready is low while a request is in work
//   or a result waits on the output
// reset (rst_n low, synchronous) empties histogram and code state; no clearing pass
module huffman_code_builder_core
  import hcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [8:0] symbol_total, [9] present, [16:10] code_length,
                                  // [80:17] code, [87:81] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CNT_RD  = 5'd1;
  localparam logic [4:0] S_CNT_WR  = 5'd2;
  localparam logic [4:0] S_QRY_RD  = 5'd3;
  localparam logic [4:0] S_QRY_OUT = 5'd4;
  localparam logic [4:0] S_SCAN_RD = 5'd5;
  localparam logic [4:0] S_SCAN_CK = 5'd6;
  localparam logic [4:0] S_RB_ST   = 5'd7;
  localparam logic [4:0] S_SD_A    = 5'd8;
  localparam logic [4:0] S_SD_B    = 5'd9;
  localparam logic [4:0] S_SD_L    = 5'd10;
  localparam logic [4:0] S_SD_C    = 5'd11;
  localparam logic [4:0] S_SD_D    = 5'd12;
  localparam logic [4:0] S_SD_END  = 5'd13;
  localparam logic [4:0] S_RB_DONE = 5'd14;
  localparam logic [4:0] S_LOOP    = 5'd15;
  localparam logic [4:0] S_POP0    = 5'd16;
  localparam logic [4:0] S_POP1    = 5'd17;
  localparam logic [4:0] S_POP_WR  = 5'd18;
  localparam logic [4:0] S_MERGE   = 5'd19;
  localparam logic [4:0] S_ROOT_RD = 5'd20;
  localparam logic [4:0] S_ROOT    = 5'd21;
  localparam logic [4:0] S_TREE_RD = 5'd22;
  localparam logic [4:0] S_TREE_WL = 5'd23;
  localparam logic [4:0] S_TREE_WR = 5'd24;
  localparam logic [4:0] S_FIN_RD  = 5'd25;
  localparam logic [4:0] S_FIN_CK  = 5'd26;
  localparam logic [4:0] S_DONE    = 5'd27;

  // what follows a heap rebuild
  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_POPA  = 2'd1;
  localparam logic [1:0] PH_POPB  = 2'd2;
  localparam logic [1:0] PH_MERGE = 2'd3;

  localparam logic [NODE_W-1:0] FIRST_MERGED = NODE_W'(SYMBOLS);

  logic [4:0]        state_r, state_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              ovf_r, ovf_nxt;
  logic              built_r, built_nxt;
  logic [8:0]        symtot_r, symtot_nxt;
  logic [SYMBOLS-1:0] vld_r, vld_nxt;
  logic              vldq_r;
  logic [8:0]        size_r, size_nxt;
  logic [7:0]        ri_r, ri_nxt;
  logic [7:0]        at_r, at_nxt;
  heap_ent_t         cur_r, cur_nxt;
  heap_ent_t         lv_r, lv_nxt;
  heap_ent_t         a_r, a_nxt;
  heap_ent_t         b_r, b_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [NODE_W-1:0] next_r, next_nxt;
  logic [NODE_W-1:0] k_r, k_nxt;
  logic [SYM_W-1:0]  s_r, s_nxt;
  logic              tl_r, tl_nxt;
  logic [NODE_W-1:0] rc_r, rc_nxt;
  path_ent_t         pp_r, pp_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  logic [8:0]        o_symtot_r, o_symtot_nxt;
  logic              o_present_r, o_present_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  logic [CODE_W-1:0] o_code_r, o_code_nxt;

  // ram ports
  logic              cnt_we;
  logic [7:0]        cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_q;
  logic              hp_we;
  logic [7:0]        hp_waddr, hp_raddr;
  heap_ent_t         hp_wdata, hp_rdata;
  logic              ch_we;
  logic [7:0]        ch_waddr, ch_raddr;
  logic [2*NODE_W-1:0] ch_wdata, ch_rdata;
  logic              pt_we;
  logic [NODE_W-1:0] pt_waddr, pt_raddr;
  path_ent_t         pt_wdata, pt_rdata;
  logic              cd_we;
  logic [7:0]        cd_waddr, cd_raddr;
  logic [LEN_W+CODE_W-1:0] cd_wdata, cd_rdata;

  // sift compare unit
  logic [9:0]        l_idx, r_idx;
  logic              l_in, r_in;
  heap_ent_t         best;
  logic [7:0]        sm;
  logic              in_acc;

  hcb_ram #(.W(CNT_W), .D(SYMBOLS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  hcb_ram #(.W(CNT_W + NODE_W), .D(SYMBOLS)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hp_raddr), .rdata(hp_rdata)
  );
  hcb_ram #(.W(2 * NODE_W), .D(SYMBOLS)) u_child (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );
  hcb_ram #(.W(PLEN_W + CODE_W), .D(NODES)) u_path (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );
  hcb_ram #(.W(LEN_W + CODE_W), .D(SYMBOLS)) u_code (
    .clk(clk), .we(cd_we), .waddr(cd_waddr), .wdata(cd_wdata),
    .raddr(cd_raddr), .rdata(cd_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !out_vld_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {7'd0, o_code_r, o_len_r, o_present_r, o_symtot_r};

  // a count never written reads as zero
  assign cnt_q = vldq_r ? cnt_rdata : '0;

  // children of the slot being sifted, and the smallest of the three
  assign l_idx = {1'b0, at_r, 1'b1};
  assign r_idx = l_idx + 10'd1;
  assign l_in  = l_idx < {1'b0, size_r};
  assign r_in  = r_idx < {1'b0, size_r};

  always_comb begin
    best = cur_r;
    sm   = at_r;
    if (lv_r.w < cur_r.w) begin
      best = lv_r;
      sm   = l_idx[7:0];
    end
    if (r_in && (hp_rdata.w < best.w)) begin
      best = hp_rdata;
      sm   = r_idx[7:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    built_nxt     = built_r;
    symtot_nxt    = symtot_r;
    vld_nxt       = vld_r;
    size_nxt      = size_r;
    ri_nxt        = ri_r;
    at_nxt        = at_r;
    cur_nxt       = cur_r;
    lv_nxt        = lv_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ph_nxt        = ph_r;
    next_nxt      = next_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    tl_nxt        = tl_r;
    rc_nxt        = rc_r;
    pp_nxt        = pp_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_symtot_nxt  = o_symtot_r;
    o_present_nxt = o_present_r;
    o_len_nxt     = o_len_r;
    o_code_nxt    = o_code_r;
    cnt_we    = 1'b0;
    cnt_waddr = sym_r;
    cnt_wdata = cnt_q + CNT_W'(1);
    cnt_raddr = sym_r;
    hp_we     = 1'b0;
    hp_waddr  = at_r;
    hp_wdata  = cur_r;
    hp_raddr  = at_r;
    ch_we     = 1'b0;
    ch_waddr  = next_r[7:0];
    ch_wdata  = (a_r.w > b_r.w) ? {b_r.node, a_r.node} : {a_r.node, b_r.node};
    ch_raddr  = k_r[7:0];
    pt_we     = 1'b0;
    pt_waddr  = ch_rdata[2*NODE_W-1:NODE_W];
    pt_wdata  = '{len: pt_rdata.len + PLEN_W'(1), bits: pt_rdata.bits << 1};
    pt_raddr  = k_r;
    cd_we     = 1'b0;
    cd_waddr  = s_r;
    cd_wdata  = {pt_rdata.len[LEN_W-1:0], pt_rdata.bits};
    cd_raddr  = sym_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sym_nxt = in_tdata;
          unique case (in_tuser)
            REQ_COUNT: begin
              built_nxt = 1'b0;
              if (total_r == '1) begin
                ovf_nxt = 1'b1;
              end else begin
                total_nxt = total_r + CNT_W'(1);
                state_nxt = S_CNT_RD;
              end
            end
            REQ_BUILD: begin
              built_nxt = 1'b0;
              if (ovf_r) begin
                out_vld_nxt   = 1'b1;
                o_status_nxt  = ST_OVERFLOW;
                o_symtot_nxt  = symtot_r;
                o_present_nxt = 1'b0;
                o_len_nxt     = '0;
                o_code_nxt    = '0;
              end else begin
                size_nxt  = '0;
                s_nxt     = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            REQ_QUERY: begin
              if (!built_r) begin
                out_vld_nxt   = 1'b1;
                o_status_nxt  = ST_UNBUILT;
                o_symtot_nxt  = symtot_r;
                o_present_nxt = 1'b0;
                o_len_nxt     = '0;
                o_code_nxt    = '0;
              end else begin
                state_nxt = S_QRY_RD;
              end
            end
            REQ_CLEAR: begin
              total_nxt  = '0;
              ovf_nxt    = 1'b0;
              built_nxt  = 1'b0;
              symtot_nxt = '0;
              vld_nxt    = '0;
              size_nxt   = '0;
            end
            default: ;
          endcase
        end
      end

      // count read-modify-write
      S_CNT_RD: begin
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        cnt_we         = 1'b1;
        vld_nxt[sym_r] = 1'b1;
        if (cnt_q == '0) begin
          symtot_nxt = symtot_r + 9'd1;
        end
        state_nxt = S_IDLE;
      end

      // query
      S_QRY_RD: begin
        state_nxt = S_QRY_OUT;
      end
      S_QRY_OUT: begin
        out_vld_nxt   = 1'b1;
        o_status_nxt  = ST_OK;
        o_symtot_nxt  = symtot_r;
        o_present_nxt = cnt_q != '0;
        o_len_nxt     = (cnt_q != '0) ? cd_rdata[LEN_W+CODE_W-1:CODE_W] : '0;
        o_code_nxt    = (cnt_q != '0) ? cd_rdata[CODE_W-1:0] : '0;
        state_nxt     = S_IDLE;
      end

      // leaves into the heap in symbol order
      S_SCAN_RD: begin
        cnt_raddr = s_r;
        state_nxt = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (cnt_q != '0) begin
          hp_we    = 1'b1;
          hp_waddr = size_r[7:0];
          hp_wdata = '{w: cnt_q, node: {1'b0, s_r}};
          size_nxt = size_r + 9'd1;
        end
        if (s_r == 8'hff) begin
          if ((cnt_q == '0) && (size_r == '0)) begin
            out_vld_nxt   = 1'b1;
            o_status_nxt  = ST_EMPTY;
            o_symtot_nxt  = symtot_r;
            o_present_nxt = 1'b0;
            o_len_nxt     = '0;
            o_code_nxt    = '0;
            state_nxt     = S_IDLE;
          end else begin
            ph_nxt    = PH_INIT;
            next_nxt  = FIRST_MERGED;
            state_nxt = S_RB_ST;
          end
        end else begin
          s_nxt     = s_r + 8'd1;
          state_nxt = S_SCAN_RD;
        end
      end

      // full bottom-up rebuild of the heap
      S_RB_ST: begin
        if (size_r < 9'd2) begin
          state_nxt = S_RB_DONE;
        end else begin
          ri_nxt    = 8'((size_r - 9'd2) >> 1);
          at_nxt    = 8'((size_r - 9'd2) >> 1);
          state_nxt = S_SD_A;
        end
      end
      S_SD_A: begin
        hp_raddr  = at_r;
        state_nxt = S_SD_B;
      end
      S_SD_B: begin
        cur_nxt   = hp_rdata;
        state_nxt = S_SD_L;
      end
      S_SD_L: begin
        if (l_in) begin
          hp_raddr  = l_idx[7:0];
          state_nxt = S_SD_C;
        end else begin
          state_nxt = S_SD_END;
        end
      end
      S_SD_C: begin
        lv_nxt    = hp_rdata;
        hp_raddr  = r_idx[7:0];
        state_nxt = S_SD_D;
      end
      S_SD_D: begin
        if (sm == at_r) begin
          state_nxt = S_SD_END;
        end else begin
          hp_we     = 1'b1;
          hp_waddr  = at_r;
          hp_wdata  = best;
          at_nxt    = sm;
          state_nxt = S_SD_L;
        end
      end
      S_SD_END: begin
        hp_we    = 1'b1;
        hp_waddr = at_r;
        hp_wdata = cur_r;
        if (ri_r == '0) begin
          state_nxt = S_RB_DONE;
        end else begin
          ri_nxt    = ri_r - 8'd1;
          at_nxt    = ri_r - 8'd1;
          state_nxt = S_SD_A;
        end
      end
      S_RB_DONE: begin
        unique case (ph_r)
          PH_INIT:  state_nxt = S_LOOP;
          PH_POPA: begin
            ph_nxt    = PH_POPB;
            state_nxt = S_POP0;
          end
          PH_POPB:  state_nxt = S_MERGE;
          PH_MERGE: state_nxt = S_LOOP;
          default:  state_nxt = S_LOOP;
        endcase
      end

      // merge loop
      S_LOOP: begin
        if (size_r > 9'd1) begin
          ph_nxt    = PH_POPA;
          state_nxt = S_POP0;
        end else begin
          state_nxt = S_ROOT_RD;
        end
      end
      S_POP0: begin
        hp_raddr  = '0;
        state_nxt = S_POP1;
      end
      S_POP1: begin
        if (ph_r == PH_POPA) begin
          a_nxt = hp_rdata;
        end else begin
          b_nxt = hp_rdata;
        end
        hp_raddr  = 8'(size_r - 9'd1);
        state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        hp_we     = 1'b1;
        hp_waddr  = '0;
        hp_wdata  = hp_rdata;
        size_nxt  = size_r - 9'd1;
        state_nxt = S_RB_ST;
      end
      S_MERGE: begin
        hp_we     = 1'b1;
        hp_waddr  = size_r[7:0];
        hp_wdata  = '{w: a_r.w + b_r.w, node: next_r};
        ch_we     = 1'b1;
        size_nxt  = size_r + 9'd1;
        next_nxt  = next_r + 9'd1;
        ph_nxt    = PH_MERGE;
        state_nxt = S_RB_ST;
      end

      // paths from the root, newest parent first
      S_ROOT_RD: begin
        hp_raddr  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        pt_we    = 1'b1;
        pt_waddr = hp_rdata.node;
        pt_wdata = '{len: '0, bits: '0};
        k_nxt    = next_r - 9'd1;
        s_nxt    = '0;
        tl_nxt   = 1'b0;
        state_nxt = (next_r == FIRST_MERGED) ? S_FIN_RD : S_TREE_RD;
      end
      S_TREE_RD: begin
        state_nxt = S_TREE_WL;
      end
      S_TREE_WL: begin
        pt_we     = 1'b1;
        rc_nxt    = ch_rdata[NODE_W-1:0];
        pp_nxt    = pt_rdata;
        state_nxt = S_TREE_WR;
      end
      S_TREE_WR: begin
        pt_we    = 1'b1;
        pt_waddr = rc_r;
        pt_wdata = '{len: pp_r.len + PLEN_W'(1), bits: {pp_r.bits[CODE_W-2:0], 1'b1}};
        if (k_r == FIRST_MERGED) begin
          state_nxt = S_FIN_RD;
        end else begin
          k_nxt     = k_r - 9'd1;
          state_nxt = S_TREE_RD;
        end
      end

      // leaf paths into the code table
      S_FIN_RD: begin
        cnt_raddr = s_r;
        pt_raddr  = {1'b0, s_r};
        state_nxt = S_FIN_CK;
      end
      S_FIN_CK: begin
        if (cnt_q != '0) begin
          if (pt_rdata.len > PLEN_W'(CODE_W)) begin
            tl_nxt = 1'b1;
          end else begin
            cd_we = 1'b1;
          end
        end
        if (s_r == 8'hff) begin
          state_nxt = S_DONE;
        end else begin
          s_nxt     = s_r + 8'd1;
          state_nxt = S_FIN_RD;
        end
      end
      S_DONE: begin
        built_nxt     = !tl_r;
        out_vld_nxt   = 1'b1;
        o_status_nxt  = tl_r ? ST_OVERFLOW : ST_OK;
        o_symtot_nxt  = symtot_r;
        o_present_nxt = 1'b0;
        o_len_nxt     = '0;
        o_code_nxt    = '0;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      ovf_r     <= 1'b0;
      built_r   <= 1'b0;
      symtot_r  <= '0;
      vld_r     <= '0;
      size_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      ovf_r     <= ovf_nxt;
      built_r   <= built_nxt;
      symtot_r  <= symtot_nxt;
      vld_r     <= vld_nxt;
      size_r    <= size_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    vldq_r      <= vld_r[cnt_raddr];
    sym_r       <= sym_nxt;
    ri_r        <= ri_nxt;
    at_r        <= at_nxt;
    cur_r       <= cur_nxt;
    lv_r        <= lv_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ph_r        <= ph_nxt;
    next_r      <= next_nxt;
    k_r         <= k_nxt;
    s_r         <= s_nxt;
    tl_r        <= tl_nxt;
    rc_r        <= rc_nxt;
    pp_r        <= pp_nxt;
    o_status_r  <= o_status_nxt;
    o_symtot_r  <= o_symtot_nxt;
    o_present_r <= o_present_nxt;
    o_len_r     <= o_len_nxt;
    o_code_r    <= o_code_nxt;
  end

  // checks
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= 9'(SYMBOLS)) else $error("heap size past symbol count");

  a_symtot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    symtot_r <= 9'(SYMBOLS)) else $error("distinct symbol count too large");

  a_built_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(state_r) == S_DONE) else $error("built set outside build end");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SD_D) |-> ({1'b0, at_r} < size_r)) else $error("sift slot outside heap");

  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while request in work");

endmodule
